// ===== rtl/cabd_pkg.sv =====
`default_nettype none

package cabd_pkg;

    // symbol table, index 0 first; the last entry is the pad
    localparam int ALPHA_LEN = 65;
    localparam logic [ALPHA_LEN*8-1:0] ALPHABET =
        "abcdefghijklmnopqrstuvwxyz~!@#$%^&*(ABCDEFGHIJKLMNOPQRSTUVWXYZ)-|";

    localparam logic [6:0] PAD_SEXTET = 7'd64;
    localparam logic [6:0] NO_SEXTET  = 7'h7f;

    // classified character as it travels from front to back
    typedef struct packed {
        logic       eot;
        logic [6:0] sextet;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // result as held in the output register
    typedef struct packed {
        logic        last;
        logic        bad;
        logic [23:0] bytes;
    } t_result;

    // map one character to its sextet, NO_SEXTET when outside the table
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] r;
        r = NO_SEXTET;
        for (int k = 0; k < ALPHA_LEN; k++) begin
            if (ALPHABET[(ALPHA_LEN-1-k)*8 +: 8] == ch) begin
                r = 7'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/custom_alphabet_base64_decoder.sv =====
`default_nettype none

// Streaming base64 decoder over a 65-symbol alphabet (lower case, ~!@#$%^&*(,
// upper case, )-, with '|' as pad). One character is taken per transfer on
// the slave side, tlast marking the end of the text. Every fourth character
// of a group yields one result transfer carrying three bytes; an invalid
// character, a misplaced pad or a group cut short by tlast yields a result
// with the error flag in tuser set and all bytes zero, and after an error the
// rest of the text up to its tlast character is dropped without results.
// Throughput is one character per clock while the queue has room: a front
// stage looks up the symbol and writes it into a queue of QUEUE_DEPTH
// entries, a back stage runs the group state and loads the output register.
// A result reaches the master side from the character that completes it
// through the queue write and then the output register; the queue lets the
// input keep flowing while the output is stalled, until its entries are full.
module custom_alphabet_base64_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character input
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] symbol
    input  wire logic        i_s_tlast,   // end_of_text
    // decoded output
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [7:0] byte_first, [15:8] byte_second,
                                          // [23:16] byte_third
    output logic             o_m_tuser,   // [0] bad_input
    output logic             o_m_tlast    // final_group
);
    import cabd_pkg::*;

    logic    push, pop;
    t_item   item_in, item_head;
    t_q_stat q_stat;
    t_result result;

    // symbol lookup and input handshake
    cabd_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_item     (item_in)
    );

    // classified characters waiting for the group logic
    cabd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item_in),
        .i_pop   (pop),
        .o_head  (item_head),
        .o_stat  (q_stat)
    );

    // group assembly, pad checks, byte packing and output register
    cabd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (item_head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (result)
    );

    assign o_m_tdata = result.bytes;
    assign o_m_tuser = result.bad;
    assign o_m_tlast = result.last;

    // an error result never carries decoded bytes
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 24'd0))
        else $error("error result with nonzero bytes");

    // the queue cannot be empty and full at once
    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue status inconsistent");

    // the back side only takes items that exist
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // a transfer into the queue leaves it nonempty
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !q_stat.empty)
        else $error("accepted character lost");

endmodule

`default_nettype wire

// ===== rtl/cabd_front.sv =====
`default_nettype none

module cabd_front (
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire logic [7:0]     i_s_tdata,
    input  wire logic           i_s_tlast,
    input  wire cabd_pkg::t_q_stat i_q_stat,
    output logic                o_push,
    output cabd_pkg::t_item     o_item
);
    import cabd_pkg::*;

    // accept whenever the queue has room
    assign o_s_tready    = ~i_q_stat.full;
    assign o_push        = i_s_tvalid & ~i_q_stat.full;
    assign o_item.sextet = sextet_of(i_s_tdata);
    assign o_item.eot    = i_s_tlast;

endmodule

`default_nettype wire

// ===== rtl/cabd_queue.sv =====
`default_nettype none

module cabd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cabd_pkg::t_item   i_item,
    input  wire logic              i_pop,
    output cabd_pkg::t_item        o_head,
    output cabd_pkg::t_q_stat      o_stat
);
    import cabd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cabd_back.sv =====
`default_nettype none

module cabd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cabd_pkg::t_item   i_head,
    input  wire cabd_pkg::t_q_stat i_q_stat,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output cabd_pkg::t_result      o_result
);
    import cabd_pkg::*;

    logic [1:0]  r_pos, n_pos;
    logic        r_disc, n_disc;
    logic [6:0]  r_held [3];
    logic        r_valid;
    t_result     r_out;
    t_result     res;
    logic        has_res;
    logic        wr_held;
    logic [6:0]  s0, s1, s2, s3;
    logic        bad_pad;

    // take the next item whenever the output register is free or draining
    assign o_pop = ~i_q_stat.empty & (~r_valid | i_m_tready);

    assign s0 = r_held[0];
    assign s1 = r_held[1];
    assign s2 = r_held[2];
    assign s3 = i_head.sextet;
    assign bad_pad = (s0 == PAD_SEXTET) | (s1 == PAD_SEXTET) |
                     ((s2 == PAD_SEXTET) & (s3 != PAD_SEXTET));

    always_comb begin
        n_pos     = r_pos;
        n_disc    = r_disc;
        has_res   = 1'b0;
        wr_held   = 1'b0;
        res.last  = i_head.eot;
        res.bad   = 1'b1;
        res.bytes = '0;
        if (r_disc) begin
            if (i_head.eot) begin
                n_disc = 1'b0;
                n_pos  = '0;
            end
        end else if (i_head.sextet == NO_SEXTET) begin
            has_res = 1'b1;
            n_pos   = '0;
            n_disc  = ~i_head.eot;
        end else if (r_pos != 2'd3) begin
            wr_held = 1'b1;
            if (i_head.eot) begin
                // group cut short by the end of text
                has_res = 1'b1;
                n_pos   = '0;
            end else begin
                n_pos = r_pos + 2'd1;
            end
        end else begin
            has_res = 1'b1;
            n_pos   = '0;
            if (bad_pad) begin
                n_disc = ~i_head.eot;
            end else begin
                res.bad          = 1'b0;
                res.bytes[7:0]   = {s0[5:0], s1[5:4]};
                res.bytes[15:8]  = (s2 == PAD_SEXTET) ? 8'd0 : {s1[3:0], s2[5:2]};
                res.bytes[23:16] = (s3 == PAD_SEXTET) ? 8'd0 : {s2[1:0], s3[5:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && wr_held) begin
            r_held[r_pos] <= i_head.sextet;
        end
        if (o_pop && has_res) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_disc  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos  <= n_pos;
                r_disc <= n_disc;
            end
            if (o_pop && has_res) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_out;

endmodule

`default_nettype wire
